@@ hw/rtl/msce_pkg.sv @@
// ----------------------------------------------------------------------------
// msce_pkg
// Types and constants shared by the monotone cubic slope estimator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msce_pkg;

    // Internal datapath width of the shared arithmetic unit
    localparam int ACC_W  = 64;
    // One quotient or multiplier bit per iteration
    localparam int ITER_N = ACC_W;
    localparam int CNT_W  = $clog2(ITER_N);

    typedef struct packed {
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic               final_knot;
    } knot_t;

    typedef struct packed {
        logic signed [31:0] slope;
        logic [15:0]        knot_index;
        logic               last_slope;
        logic               zero_spacing;
    } slope_t;

    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MUL = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic             start;
        arith_op_t        op;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             neg;
    } arith_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [ACC_W-1:0] result;
    } arith_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/msce_arith.sv @@
// ----------------------------------------------------------------------------
// msce_arith
// Shared bit-serial unit: unsigned restoring divide or shift-add multiply of
// magnitudes, one bit per cycle, with the result sign applied at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module msce_arith (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire msce_pkg::arith_req_t req,
    output msce_pkg::arith_rsp_t      rsp
);
    import msce_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    arith_op_t        op_reg;
    logic             neg_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] sh_reg;
    logic [ACC_W-1:0] opnd_reg;

    logic [ACC_W:0]   trial;
    logic [ACC_W:0]   diff;
    logic             ge;
    logic [ACC_W-1:0] madd;
    logic [ACC_W-1:0] mag;

    assign trial = {acc_reg, sh_reg[ACC_W-1]};
    assign diff  = trial - {1'b0, opnd_reg};
    assign ge    = (trial >= {1'b0, opnd_reg});
    assign madd  = {acc_reg[ACC_W-2:0], 1'b0} + (sh_reg[ACC_W-1] ? opnd_reg : '0);
    assign mag   = (op_reg == OP_MUL) ? acc_reg : sh_reg;

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = neg_reg ? -$signed(mag) : $signed(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ITER_N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            op_reg  <= req.op;
            neg_reg <= req.neg;
            acc_reg <= '0;
            if (req.op == OP_DIV) begin
                sh_reg   <= req.a;
                opnd_reg <= req.b;
            end else begin
                sh_reg   <= req.b;
                opnd_reg <= req.a;
            end
        end else if (busy_reg) begin
            if (op_reg == OP_DIV) begin
                acc_reg <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
                sh_reg  <= {sh_reg[ACC_W-2:0], ge};
            end else begin
                acc_reg <= madd;
                sh_reg  <= {sh_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/monotone_cubic_slope_estimator_unit.sv @@
// First knot of a set: stored only (plus its slope if it is the only knot).
// Second knot: one secant divide. Later knots: secant, two ratio divides,
// then up to 7 more operations for the interior slope and 1 per end slope;
// the unit takes one knot at a time.
// Reset (aresetn low, synchronous) returns to idle at knot index 0.
// ----------------------------------------------------------------------------
// monotone_cubic_slope_estimator_unit
// Streaming shape-preserving Hermite slope estimator over Q knots, built
// around one shared iterative divide/multiply unit and a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module monotone_cubic_slope_estimator_unit #(
    parameter int MAX_KNOTS = 65536,
    parameter int FRAC_BITS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire msce_pkg::knot_t s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output msce_pkg::slope_t     m_data
);
    import msce_pkg::*;

    localparam int KNOT_LIMIT = (MAX_KNOTS < 65536) ? MAX_KNOTS : 65536;
    localparam logic [15:0] LAST_IDX = 16'(KNOT_LIMIT - 1);
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] RCAP  = 64'sd1 <<< 30;
    // Divide by 3 as multiply by ceil(2^33 / 3), then shift right by 33;
    // exact for every magnitude below 2^32
    localparam logic [63:0] RECIP3       = 64'd2863311531;
    localparam int          RECIP3_SHIFT = 33;

    // Sequencer states
    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_SEC   = 16'b0000_0000_0000_0010,
        S_TWO   = 16'b0000_0000_0000_0100,
        S_RATB  = 16'b0000_0000_0000_1000,
        S_RATA  = 16'b0000_0000_0001_0000,
        S_ENDM  = 16'b0000_0000_0010_0000,
        S_ENDE  = 16'b0000_0000_0100_0000,
        S_INNER = 16'b0000_0000_1000_0000,
        S_W1    = 16'b0000_0001_0000_0000,
        S_W2    = 16'b0000_0010_0000_0000,
        S_DR1   = 16'b0000_0100_0000_0000,
        S_DR2   = 16'b0000_1000_0000_0000,
        S_M1    = 16'b0001_0000_0000_0000,
        S_M2    = 16'b0010_0000_0000_0000,
        S_IDIV  = 16'b0100_0000_0000_0000,
        S_EMIT  = 16'b1000_0000_0000_0000
    } state_t;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Divide by 2^FRAC_BITS, truncating toward zero
    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v);
        logic signed [63:0] n;
        n = -v;
        return v[63] ? -(n >>> FRAC_BITS) : (v >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] clamp_ratio(input logic signed [63:0] v);
        if (v > RCAP) begin
            return 32'(RCAP);
        end else if (v < -RCAP) begin
            return 32'(-RCAP);
        end
        return 32'(v);
    endfunction

    state_t             state_reg;
    state_t             ret_reg;
    logic               issued_reg;
    logic [15:0]        kc_reg;
    logic [15:0]        idx_reg;
    logic               fin_reg;
    logic               end_last_reg;
    logic signed [31:0] held_x_reg;
    logic signed [31:0] held_y_reg;
    logic signed [32:0] h_reg;
    logic signed [32:0] dy_reg;
    logic signed [32:0] sb_reg;
    logic signed [32:0] sa_reg;
    logic signed [31:0] db_reg;
    logic signed [31:0] da_reg;
    logic signed [31:0] rb_reg;
    logic signed [31:0] ra_reg;
    logic signed [31:0] w1_reg;
    logic signed [31:0] w2_reg;
    logic signed [31:0] dr1_reg;
    logic signed [31:0] dr2_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [63:0] t_reg;
    slope_t             pend_reg;
    logic               m_valid_reg;
    slope_t             m_data_reg;

    arith_req_t         areq;
    arith_rsp_t         arsp;
    logic               op_state;
    logic               skip;
    logic               fire;
    logic signed [63:0] res;

    logic               fin_in;
    logic signed [33:0] hsum;
    logic               zs;
    logic [31:0]        adb;
    logic [31:0]        ada;
    logic [31:0]        dmax;
    logic [31:0]        dmin;
    logic               same_sign;
    logic signed [31:0] d_e;
    logic signed [31:0] e_e;
    logic signed [32:0] diff_de;
    logic signed [31:0] r_e;
    logic signed [63:0] p_end;
    logic signed [63:0] m3;
    logic signed [63:0] es;
    logic               kill;
    logic               flip;
    logic signed [63:0] den;
    logic signed [63:0] w1_num;
    logic signed [63:0] w2_num;
    logic signed [31:0] w_third;
    logic [15:0]        idx_m1;

    msce_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .rsp     (arsp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign fin_in = s_data.final_knot || (kc_reg >= LAST_IDX);
    assign hsum   = 34'(sb_reg) + 34'(sa_reg);
    assign zs     = (sb_reg == '0) || (sa_reg == '0);
    assign adb    = 32'(abs64(64'(db_reg)));
    assign ada    = 32'(abs64(64'(da_reg)));
    assign dmax   = (adb > ada) ? adb : ada;
    assign dmin   = (adb > ada) ? ada : adb;
    assign idx_m1 = idx_reg - 16'd1;
    assign same_sign = (db_reg > 0 && da_reg > 0) || (db_reg < 0 && da_reg < 0);

    // End slope: d is the adjacent secant, e the far one
    assign d_e     = end_last_reg ? da_reg : db_reg;
    assign e_e     = end_last_reg ? db_reg : da_reg;
    assign r_e     = end_last_reg ? ra_reg : rb_reg;
    assign diff_de = 33'(d_e) - 33'(e_e);
    assign p_end   = 64'(d_e) + shr_trunc(t_reg);
    assign m3      = (64'(d_e) <<< 1) + 64'(d_e);
    assign kill    = !((p_end > 0 && d_e > 0) || (p_end < 0 && d_e < 0));
    assign flip    = (d_e > 0 && e_e < 0) || (d_e < 0 && e_e > 0);
    always_comb begin
        if (kill) begin
            es = '0;
        end else if (flip && (abs64(p_end) > abs64(m3))) begin
            es = m3;
        end else begin
            es = p_end;
        end
    end

    assign den     = shr_trunc(p1_reg + p2_reg);
    assign w1_num  = ONE_Q + 64'(rb_reg);
    assign w2_num  = ONE_Q + 64'(ra_reg);
    // Magnitude over 3 from the reciprocal product
    assign w_third = 32'(res >>> RECIP3_SHIFT);

    // Operand selection for the shared unit
    always_comb begin
        areq.op  = OP_DIV;
        areq.a   = '0;
        areq.b   = '0;
        areq.neg = 1'b0;
        op_state = 1'b1;
        skip     = 1'b0;
        case (state_reg)
            S_SEC: begin
                areq.a   = abs64(64'(dy_reg)) << FRAC_BITS;
                areq.b   = abs64(64'(h_reg));
                areq.neg = dy_reg[32] ^ h_reg[32];
                skip     = (h_reg == '0);
            end
            S_RATB: begin
                areq.a   = abs64(64'(sb_reg)) << FRAC_BITS;
                areq.b   = abs64(64'(hsum));
                areq.neg = sb_reg[32] ^ hsum[33];
                skip     = (hsum == '0);
            end
            S_RATA: begin
                areq.a   = abs64(64'(sa_reg)) << FRAC_BITS;
                areq.b   = abs64(64'(hsum));
                areq.neg = sa_reg[32] ^ hsum[33];
                skip     = (hsum == '0);
            end
            S_ENDM: begin
                areq.op  = OP_MUL;
                areq.a   = abs64(64'(diff_de));
                areq.b   = abs64(64'(r_e));
                areq.neg = diff_de[32] ^ r_e[31];
            end
            S_W1: begin
                areq.op  = OP_MUL;
                areq.a   = abs64(w1_num);
                areq.b   = RECIP3;
            end
            S_W2: begin
                areq.op  = OP_MUL;
                areq.a   = abs64(w2_num);
                areq.b   = RECIP3;
            end
            S_DR1: begin
                areq.a   = abs64(64'(db_reg)) << FRAC_BITS;
                areq.b   = 64'(dmax);
                areq.neg = db_reg[31];
            end
            S_DR2: begin
                areq.a   = abs64(64'(da_reg)) << FRAC_BITS;
                areq.b   = 64'(dmax);
                areq.neg = da_reg[31];
            end
            S_M1: begin
                areq.op  = OP_MUL;
                areq.a   = abs64(64'(w1_reg));
                areq.b   = abs64(64'(dr1_reg));
                areq.neg = w1_reg[31] ^ dr1_reg[31];
            end
            S_M2: begin
                areq.op  = OP_MUL;
                areq.a   = abs64(64'(w2_reg));
                areq.b   = abs64(64'(dr2_reg));
                areq.neg = w2_reg[31] ^ dr2_reg[31];
            end
            S_IDIV: begin
                areq.a   = 64'(dmin) << FRAC_BITS;
                areq.b   = abs64(den);
                areq.neg = den[63];
                skip     = (den == '0);
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
        areq.start = op_state && !skip && !issued_reg && !arsp.busy;
        fire       = op_state && (skip || (issued_reg && arsp.done));
        res        = skip ? '0 : arsp.result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            issued_reg   <= 1'b0;
            kc_reg       <= '0;
            end_last_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // Drop the result once the consumer takes the transaction,
            // unless a new one is loaded in the same cycle
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            if (areq.start) begin
                issued_reg <= 1'b1;
            end
            if (fire) begin
                issued_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        idx_reg    <= kc_reg;
                        fin_reg    <= fin_in;
                        h_reg      <= 33'(s_data.knot_x) - 33'(held_x_reg);
                        dy_reg     <= 33'(s_data.knot_y) - 33'(held_y_reg);
                        held_x_reg <= s_data.knot_x;
                        held_y_reg <= s_data.knot_y;
                        kc_reg     <= fin_in ? 16'd0 : kc_reg + 16'd1;
                        if (kc_reg == '0) begin
                            // Single knot set: slope 0
                            if (fin_in) begin
                                pend_reg  <= '{slope: '0, knot_index: '0,
                                               last_slope: 1'b1, zero_spacing: 1'b0};
                                ret_reg   <= S_IDLE;
                                state_reg <= S_EMIT;
                            end
                        end else begin
                            state_reg <= S_SEC;
                        end
                    end
                end
                S_SEC: begin
                    if (fire) begin
                        if (idx_reg == 16'd1) begin
                            sb_reg <= h_reg;
                            db_reg <= sat32(res);
                            if (fin_reg) begin
                                // Two knots: secant at both ends
                                pend_reg  <= '{slope: sat32(res), knot_index: '0,
                                               last_slope: 1'b0,
                                               zero_spacing: (h_reg == '0)};
                                ret_reg   <= S_TWO;
                                state_reg <= S_EMIT;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end else begin
                            if (idx_reg != 16'd2) begin
                                sb_reg <= sa_reg;
                                db_reg <= da_reg;
                            end
                            sa_reg    <= h_reg;
                            da_reg    <= sat32(res);
                            state_reg <= S_RATB;
                        end
                    end
                end
                S_TWO: begin
                    pend_reg  <= '{slope: db_reg, knot_index: 16'd1,
                                   last_slope: 1'b1, zero_spacing: (sb_reg == '0)};
                    ret_reg   <= S_IDLE;
                    state_reg <= S_EMIT;
                end
                S_RATB: begin
                    if (fire) begin
                        rb_reg    <= clamp_ratio(res);
                        state_reg <= S_RATA;
                    end
                end
                S_RATA: begin
                    if (fire) begin
                        ra_reg       <= clamp_ratio(res);
                        end_last_reg <= 1'b0;
                        state_reg    <= (idx_reg == 16'd2) ? S_ENDM : S_INNER;
                    end
                end
                S_ENDM: begin
                    if (fire) begin
                        t_reg     <= res;
                        state_reg <= S_ENDE;
                    end
                end
                S_ENDE: begin
                    pend_reg  <= '{slope: sat32(es),
                                   knot_index: end_last_reg ? idx_reg : 16'd0,
                                   last_slope: end_last_reg, zero_spacing: zs};
                    ret_reg   <= end_last_reg ? S_IDLE : S_INNER;
                    state_reg <= S_EMIT;
                end
                S_INNER: begin
                    if (same_sign) begin
                        state_reg <= S_W1;
                    end else begin
                        // Monotonicity changes here: flat slope
                        pend_reg     <= '{slope: '0, knot_index: idx_m1,
                                          last_slope: 1'b0, zero_spacing: zs};
                        ret_reg      <= fin_reg ? S_ENDM : S_IDLE;
                        end_last_reg <= fin_reg;
                        state_reg    <= S_EMIT;
                    end
                end
                S_W1: begin
                    if (fire) begin
                        // Apply the sign after the magnitude division
                        w1_reg    <= w1_num[63] ? -w_third : w_third;
                        state_reg <= S_W2;
                    end
                end
                S_W2: begin
                    if (fire) begin
                        w2_reg    <= w2_num[63] ? -w_third : w_third;
                        state_reg <= S_DR1;
                    end
                end
                S_DR1: begin
                    if (fire) begin
                        dr1_reg   <= 32'(res);
                        state_reg <= S_DR2;
                    end
                end
                S_DR2: begin
                    if (fire) begin
                        dr2_reg   <= 32'(res);
                        state_reg <= S_M1;
                    end
                end
                S_M1: begin
                    if (fire) begin
                        p1_reg    <= res;
                        state_reg <= S_M2;
                    end
                end
                S_M2: begin
                    if (fire) begin
                        p2_reg    <= res;
                        state_reg <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    if (fire) begin
                        pend_reg     <= '{slope: sat32(res), knot_index: idx_m1,
                                          last_slope: 1'b0, zero_spacing: zs};
                        ret_reg      <= fin_reg ? S_ENDM : S_IDLE;
                        end_last_reg <= fin_reg;
                        state_reg    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= pend_reg;
                        state_reg   <= ret_reg;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
